### rtl/wbps_pkg.sv
// Package: shared constants, codes and payload/control types for the wildcard pattern scanner.
package wbps_pkg;

   // Longest pattern the cell row can hold.
   localparam int MAX_PATTERN = 64;

   localparam int POS_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   localparam int PLEN_W = 7;
   localparam int OCC_W  = 16;
   localparam int ADDR_W = 32;
   localparam int IDX_W  = 6;
   localparam int CSR_W  = 2;

   // Item opcodes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   // Register indexes.
   localparam logic [CSR_W-1:0] CSR_PATTERN_LENGTH    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_WANTED_OCCURRENCE = 2'd1;
   localparam logic [CSR_W-1:0] CSR_BASE_ADDRESS      = 2'd2;

   typedef struct packed {
      logic             opcode;
      logic [IDX_W-1:0] entry_index;
      logic [7:0]       pattern_value;
      logic             dont_care;
      logic [7:0]       data_byte;
      logic             last_byte;
   } req_payload_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } rsp_payload_type;

   // Broadcast from the controller to the cell row.
   typedef struct packed {
      logic             shift;
      logic             rot_up;
      logic             rot_dn;
      logic [POS_W-1:0] ins_pos;
      logic [LEN_W-1:0] len;
      logic [7:0]       data_byte;
      logic             load_we;
      logic [IDX_W-1:0] load_idx;
      logic [7:0]       load_value;
      logic             load_dc;
   } ring_ctrl_type;

endpackage

### rtl/wbps_cell.sv
// One cell: a window byte on the ring, one pattern entry and its compare.
module wbps_cell import wbps_pkg::*; (
   input  logic          clock,
   input  ring_ctrl_type ctrl,
   input  logic          ins,
   input  logic          active,
   input  logic          we,
   input  logic [7:0]    right_byte,
   input  logic [7:0]    left_byte,
   output logic [7:0]    win_byte,
   output logic          ok
);

   logic [7:0] win_ff, win_in;
   logic [7:0] pat_ff, pat_in;
   logic       dc_ff, dc_in;

   always_comb begin
      win_in = win_ff;
      if (ctrl.shift) begin
         win_in = ins ? ctrl.data_byte : right_byte;
      end else if (ctrl.rot_up) begin
         win_in = left_byte;
      end else if (ctrl.rot_dn) begin
         win_in = right_byte;
      end
      pat_in = we ? ctrl.load_value : pat_ff;
      dc_in  = we ? ctrl.load_dc : dc_ff;
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      pat_ff <= pat_in;
      dc_ff  <= dc_in;
   end

   assign win_byte = win_ff;
   assign ok       = !active || dc_ff || (win_ff == pat_ff);

endmodule

### rtl/wbps_row.sv
// Ring of cells and the full-window match reduction.
module wbps_row import wbps_pkg::*; (
   input  logic          clock,
   input  ring_ctrl_type ctrl,
   output logic          window_match
);

   logic [7:0]             win [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] ok;

   for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_cell
      localparam int RIGHT = (p + 1) % MAX_PATTERN;
      localparam int LEFT  = (p + MAX_PATTERN - 1) % MAX_PATTERN;
      localparam logic [LEN_W-1:0] PLEN = LEN_W'(p);
      localparam logic [POS_W-1:0] PPOS = POS_W'(p);

      logic ins, active, we;

      assign ins    = (ctrl.ins_pos == PPOS);
      assign active = (PLEN < ctrl.len);
      assign we     = ctrl.load_we && (32'(ctrl.load_idx) == 32'(p));

      wbps_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .ins        (ins),
         .active     (active),
         .we         (we),
         .right_byte (win[RIGHT]),
         .left_byte  (win[LEFT]),
         .win_byte   (win[p]),
         .ok         (ok[p])
      );
   end

   assign window_match = &ok;

endmodule

### rtl/wildcard_byte_pattern_scan.sv
// Top level: wildcard byte-pattern scanner with cell ring, match and count stages.
//
//  channel | signals                       | direction | accepted when
//  --------+-------------------------------+-----------+------------------------
//  req     | req_valid/req_ready/req_payload | in      | req_valid && req_ready
//  rsp     | rsp_valid/rsp_ready/rsp_payload | out     | rsp_valid && rsp_ready
//  csr     | csr_valid/csr_ready/csr_index/csr_data | in | csr_valid (always ready)
//
// One item per cycle, load or scan, unless req_ready is held low by a stall or a
// realign. A scan result passes through the ring update, then the window
// compare, then count/report. A stalled result holds the pipe only when another
// result is behind it. After a pattern_length write the ring realigns one cell
// per cycle while no scanned byte awaits its compare, with req_ready low. Synchronous reset; no clearing pass.
module wildcard_byte_pattern_scan import wbps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_payload_type   req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_payload_type   rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0] csr_data
);

   // Configuration registers
   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [OCC_W-1:0]  wanted_ff, wanted_in;
   logic [ADDR_W-1:0] base_ff, base_in;

   // Ring alignment: cell p holds the byte that lines up with pattern position p
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;
   logic [LEN_W-1:0]  tgt_len;
   logic              aligned, rot_ok, rot_up, rot_dn;

   // Stage 1: item sitting in the ring
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_last_ff, s1_last_in;
   logic [ADDR_W-1:0] seen_ff, seen_in;

   // Stage 2: compare result
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_hit_ff, s2_hit_in;
   logic              s2_last_ff, s2_last_in;
   logic [ADDR_W-1:0] s2_off_ff, s2_off_in;

   // Stage 3: occurrence count and report state
   logic [OCC_W-1:0]  count_ff, count_in;
   logic              reported_ff, reported_in;
   logic [OCC_W-1:0]  cnt_inc, wanted_eff;
   logic              hit, produce;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   logic              stall, adv, accept, scan_acc, load_acc, region_end;
   logic              window_match;
   ring_ctrl_type     ctrl;

   assign csr_ready = 1'b1;

   always_comb begin
      plen_in   = plen_ff;
      wanted_in = wanted_ff;
      base_in   = base_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH:    plen_in   = csr_data[PLEN_W-1:0];
            CSR_WANTED_OCCURRENCE: wanted_in = csr_data[OCC_W-1:0];
            CSR_BASE_ADDRESS:      base_in   = csr_data;
            default: ;
         endcase
      end
   end

   // Effective length: zero acts as one, clamp at the row size
   always_comb begin
      if (plen_ff == '0) begin
         tgt_len = LEN_W'(1);
      end else if (32'(plen_ff) > 32'(MAX_PATTERN)) begin
         tgt_len = LEN_W'(MAX_PATTERN);
      end else begin
         tgt_len = LEN_W'(plen_ff);
      end
   end

   assign aligned = (cur_len_ff == tgt_len);
   // never realign under an item still waiting for its compare
   assign rot_ok  = !aligned && !s1_valid_ff;
   assign rot_up  = rot_ok && (tgt_len > cur_len_ff);
   assign rot_dn  = rot_ok && (tgt_len < cur_len_ff);

   always_comb begin
      cur_len_in = cur_len_ff;
      if (rot_up) begin
         cur_len_in = cur_len_ff + LEN_W'(1);
      end else if (rot_dn) begin
         cur_len_in = cur_len_ff - LEN_W'(1);
      end
   end

   // Stage 3 combinational decision
   always_comb begin
      wanted_eff = (wanted_ff == '0) ? OCC_W'(1) : wanted_ff;
      cnt_inc    = count_ff;
      if (s2_hit_ff && (count_ff != '1)) begin
         cnt_inc = count_ff + OCC_W'(1);
      end
      hit     = s2_hit_ff && (cnt_inc >= wanted_eff);
      produce = s2_valid_ff && !reported_ff && (hit || s2_last_ff);
   end

   // Only a new result blocked by a pending one holds the pipe
   assign stall      = produce && rsp_valid_ff && !rsp_ready;
   assign adv        = !stall;
   assign req_ready  = aligned && adv;
   assign accept     = req_valid && req_ready;
   assign scan_acc   = accept && (req_payload.opcode == OP_SCAN);
   assign load_acc   = accept && (req_payload.opcode == OP_LOAD);
   assign region_end = adv && s1_valid_ff && s1_last_ff;

   always_comb begin
      ctrl            = '0;
      ctrl.shift      = scan_acc;
      ctrl.rot_up     = rot_up;
      ctrl.rot_dn     = rot_dn;
      ctrl.ins_pos    = POS_W'(cur_len_ff - LEN_W'(1));
      ctrl.len        = cur_len_ff;
      ctrl.data_byte  = req_payload.data_byte;
      ctrl.load_we    = load_acc;
      ctrl.load_idx   = req_payload.entry_index;
      ctrl.load_value = req_payload.pattern_value;
      ctrl.load_dc    = req_payload.dont_care;
   end

   wbps_row u_row (
      .clock        (clock),
      .ctrl         (ctrl),
      .window_match (window_match)
   );

   // Stage 1 and byte counter; the count restarts once the last byte moves on
   always_comb begin
      s1_valid_in = adv ? scan_acc : s1_valid_ff;
      s1_last_in  = scan_acc ? req_payload.last_byte : s1_last_ff;
      seen_in     = (region_end ? '0 : seen_ff) + ADDR_W'(scan_acc);
   end

   // Stage 2: window counts only once it lies wholly inside the region
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_hit_in   = s2_hit_ff;
      s2_last_in  = s2_last_ff;
      s2_off_in   = s2_off_ff;
      if (adv) begin
         s2_valid_in = s1_valid_ff;
         s2_hit_in   = window_match && (seen_ff >= ADDR_W'(cur_len_ff));
         s2_last_in  = s1_last_ff;
         s2_off_in   = seen_ff - ADDR_W'(cur_len_ff);
      end
   end

   // Stage 3 state and output register
   always_comb begin
      count_in       = count_ff;
      reported_in    = reported_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (adv && s2_valid_ff) begin
         if (s2_last_ff) begin
            count_in    = '0;
            reported_in = 1'b0;
         end else if (!reported_ff) begin
            count_in    = cnt_inc;
            reported_in = hit;
         end
      end
      if (adv && produce) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.found         = hit;
         rsp_payload_in.match_address = hit ? (base_ff + s2_off_ff) : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= PLEN_W'(1);
         wanted_ff    <= OCC_W'(1);
         base_ff      <= '0;
         cur_len_ff   <= LEN_W'(1);
         s1_valid_ff  <= 1'b0;
         seen_ff      <= '0;
         s2_valid_ff  <= 1'b0;
         count_ff     <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         wanted_ff    <= wanted_in;
         base_ff      <= base_in;
         cur_len_ff   <= cur_len_in;
         s1_valid_ff  <= s1_valid_in;
         seen_ff      <= seen_in;
         s2_valid_ff  <= s2_valid_in;
         count_ff     <= count_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff     <= s1_last_in;
      s2_hit_ff      <= s2_hit_in;
      s2_last_ff     <= s2_last_in;
      s2_off_ff      <= s2_off_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### rtl/wbps_checker.sv
// Port-level checks for the scanner, bound to the top level.
module wbps_checker import wbps_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // no result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a waiting result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // not-found carries a zero address
   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.match_address == '0)
      else $error("not-found result with nonzero address");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (.*);

### test/testbench.sv
`timescale 1ns / 1ps
// Testbench for the wildcard byte-pattern scanner: predicted match reports over random regions.
module testbench;
   import wbps_pkg::*;

   // No item moves for this many cycles: the block is hung. Covers the ring
   // realign after a length write many times over.
   localparam int STALL_LIMIT  = 1000;
   // Quiet cycles after the last report.
   localparam int DRAIN_CYCLES = 8;
   // Occurrence reached by a run of all-matching bytes.
   localparam int DEEP_OCCURRENCE = 150;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_payload_type   req_payload;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_payload_type   rsp_payload;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_index;
   logic [ADDR_W-1:0] csr_data;

   wildcard_byte_pattern_scan dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor state: pattern, byte window, region counters, registers.
   // recent[0] is the newest byte; pattern position p lines up with
   // recent[n-1-p] for an active length n.
   // ------------------------------------------------------------------
   logic [7:0]        want_byte [MAX_PATTERN];
   logic              any_byte  [MAX_PATTERN];
   logic [7:0]        recent    [MAX_PATTERN];
   logic [31:0]       byte_total;
   logic [15:0]       hit_total;
   logic              hold_off;     // report made, skip bytes until region end
   logic [PLEN_W-1:0] len_reg;
   logic [OCC_W-1:0]  occ_reg;
   logic [ADDR_W-1:0] base_reg;

   rsp_payload_type   expected_reports [$];

   int error_count  = 0;
   int stall_cycles = 0;

   // Stimulus side: what the pattern holds and which entries were loaded,
   // so no scan ever compares against an entry that was never written.
   logic [7:0] stim_byte   [MAX_PATTERN];
   bit         stim_any    [MAX_PATTERN];
   bit         stim_loaded [MAX_PATTERN];
   int         active_len   = 1;
   int         send_gap_pct = 0;
   int         rsp_hold_pct = 0;
   int         sent_count   = 0;

   task automatic flag_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic void clear_region_state();
      for (int k = 0; k < MAX_PATTERN; k++) recent[k] = 8'h00;
      byte_total = '0;
      hit_total  = '0;
      hold_off   = 1'b0;
   endfunction

   // One accepted item through the search; pushes the report it causes, if any.
   function automatic void search_step(input req_payload_type it);
      int              n;
      bit              hit;
      logic [15:0]     need;
      rsp_payload_type r;
      if (it.opcode == OP_LOAD) begin
         // Loads land at once, even in the middle of a region.
         want_byte[it.entry_index] = it.pattern_value;
         any_byte[it.entry_index]  = it.dont_care;
         return;
      end
      if (hold_off) begin
         // Already reported: bytes are dropped, the last one just closes the region.
         if (it.last_byte) clear_region_state();
         return;
      end
      for (int p = MAX_PATTERN - 1; p > 0; p--) recent[p] = recent[p-1];
      recent[0]  = it.data_byte;
      byte_total = byte_total + 32'd1;
      // Length 0 acts as 1, anything past the row acts as a full row.
      n    = (len_reg == 0) ? 1 : (len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(len_reg);
      need = (occ_reg == 0) ? 16'd1 : occ_reg;
      // Only windows wholly inside the region count.
      hit  = (byte_total >= n);
      for (int p = 0; p < n && hit; p++)
         if (!any_byte[p] && recent[n-1-p] != want_byte[p]) hit = 1'b0;
      if (hit) begin
         if (hit_total != 16'hFFFF) hit_total = hit_total + 16'd1;
         if (hit_total >= need) begin
            r.found         = 1'b1;
            r.match_address = base_reg + (byte_total - n);
            expected_reports.push_back(r);
            if (it.last_byte) clear_region_state();
            else hold_off = 1'b1;
            return;
         end
      end
      if (it.last_byte) begin
         // Region closed without the wanted match.
         r.found         = 1'b0;
         r.match_address = '0;
         expected_reports.push_back(r);
         clear_region_state();
      end
   endfunction

   // ------------------------------------------------------------------
   // Observer: register writes and items feed the predictor, reports are
   // checked against the oldest expectation. Runs on pre-edge values only.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         for (int k = 0; k < MAX_PATTERN; k++) begin
            want_byte[k] = 8'h00;
            any_byte[k]  = 1'b0;
         end
         clear_region_state();
         len_reg  = PLEN_W'(1);
         occ_reg  = OCC_W'(1);
         base_reg = '0;
         expected_reports.delete();
         stall_cycles <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LENGTH:    len_reg  = csr_data[PLEN_W-1:0];
               CSR_WANTED_OCCURRENCE: occ_reg  = csr_data[OCC_W-1:0];
               CSR_BASE_ADDRESS:      base_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) search_step(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               flag_mismatch($sformatf("report with none pending: found=%0b addr=%h",
                                       rsp_payload.found, rsp_payload.match_address));
            end else begin
               want = expected_reports.pop_front();
               if (rsp_payload.found !== want.found)
                  flag_mismatch($sformatf("found: got %b, want %b",
                                          rsp_payload.found, want.found));
               if (rsp_payload.match_address !== want.match_address)
                  flag_mismatch($sformatf("match_address: got %h, want %h",
                                          rsp_payload.match_address, want.match_address));
            end
         end
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   // Hang guard: nothing accepted on any channel for too long.
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // Result side back-pressure.
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_hold_pct);

   task automatic set_idling(input int gap_pct, input int hold_pct);
      send_gap_pct = gap_pct;
      rsp_hold_pct = hold_pct;
   endtask

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   // Valid stays high from one item to the next unless an idle gap is drawn,
   // so it is never dropped and raised in the same step.
   task automatic send_item(input req_payload_type it);
      if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // Register writes only with nothing in flight: drop valid, let the observer
   // take the last item, drain reports, then let bytes that report nothing
   // clear the pipe.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_W-1:0] idx, input logic [ADDR_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Upper data bits are sometimes junk; the register keeps only its own width.
   task automatic set_length(input int raw);
      logic [ADDR_W-1:0] value;
      value = ADDR_W'(raw);
      if ($urandom_range(3) == 0) value = ($urandom() & 32'hFFFF_FF80) | value;
      write_csr(CSR_PATTERN_LENGTH, value);
      active_len = (raw == 0) ? 1 : (raw > MAX_PATTERN) ? MAX_PATTERN : raw;
   endtask

   task automatic set_occurrence(input int raw);
      logic [ADDR_W-1:0] value;
      value = ADDR_W'(raw);
      if ($urandom_range(3) == 0) value = ($urandom() & 32'hFFFF_0000) | value;
      write_csr(CSR_WANTED_OCCURRENCE, value);
   endtask

   // Scan fields ride along with random junk on a load.
   task automatic load_entry(input int idx, input logic [7:0] value, input bit any);
      req_payload_type it;
      it.opcode        = OP_LOAD;
      it.entry_index   = IDX_W'(idx);
      it.pattern_value = value;
      it.dont_care     = any;
      it.data_byte     = 8'($urandom_range(255));
      it.last_byte     = 1'($urandom_range(1));
      stim_byte[idx]   = value;
      stim_any[idx]    = any;
      stim_loaded[idx] = 1'b1;
      send_item(it);
   endtask

   task automatic fill_pattern();
      for (int k = 0; k < active_len; k++)
         if (!stim_loaded[k]) load_entry(k, 8'($urandom_range(255)), ($urandom_range(4) == 0));
   endtask

   task automatic scan_byte(input logic [7:0] data, input bit last);
      req_payload_type it;
      fill_pattern();
      it.opcode        = OP_SCAN;
      it.entry_index   = IDX_W'($urandom_range(63));
      it.pattern_value = 8'($urandom_range(255));
      it.dont_care     = 1'($urandom_range(1));
      it.data_byte     = data;
      it.last_byte     = last;
      send_item(it);
   endtask

   // A byte that satisfies pattern position p.
   function automatic logic [7:0] pattern_byte(input int p);
      return stim_any[p] ? 8'($urandom_range(255)) : stim_byte[p];
   endfunction

   // ------------------------------------------------------------------
   // Random region generator
   // ------------------------------------------------------------------
   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 65) return $urandom_range(6, 1);
      if (r < 88) return $urandom_range(16, 7);
      if (r < 93) return 0;
      if (r < 96) return MAX_PATTERN;
      return $urandom_range(127, MAX_PATTERN + 1);
   endfunction

   function automatic int pick_occurrence();
      int r;
      r = $urandom_range(99);
      if (r < 40) return 1;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(5, 2);
      if (r < 95) return $urandom_range(40, 6);
      return ($urandom_range(1) == 0) ? 65535 : $urandom_range(65535);
   endfunction

   task automatic random_settings();
      if ($urandom_range(2) == 0) set_length(pick_length());
      if ($urandom_range(2) == 0) set_occurrence(pick_occurrence());
      if ($urandom_range(2) == 0) write_csr(CSR_BASE_ADDRESS, $urandom());
      if ($urandom_range(1) == 0)
         for (int k = 0; k < active_len; k++)
            if ($urandom_range(1) == 0)
               load_entry(k, 8'($urandom_range(255)), ($urandom_range(4) == 0));
      fill_pattern();
   endtask

   // Mostly regions with planted pattern copies (some damaged, some cut off
   // by the region end) among bytes drawn near the pattern; some pure noise.
   task automatic random_region();
      int         len;
      int         i;
      int         split;
      bit         noise;
      logic [7:0] b;
      fill_pattern();
      noise = ($urandom_range(99) < 15);
      len   = ($urandom_range(9) == 0) ? $urandom_range(active_len + 40, active_len)
                                       : $urandom_range(24, 1);
      split = ($urandom_range(19) == 0) ? $urandom_range(len - 1) : -1;
      i = 0;
      while (i < len) begin
         if (i == split) random_settings();   // registers change mid-region
         if (!noise && $urandom_range(99) < 30) begin
            for (int p = 0; p < active_len && i < len; p++) begin
               b = pattern_byte(p);
               if ($urandom_range(9) == 0) b = 8'($urandom_range(255));
               scan_byte(b, i == len - 1);
               i++;
            end
         end else begin
            if (noise) b = 8'($urandom_range(255));
            else begin
               case ($urandom_range(3))
                  0: b = 8'($urandom_range(255));
                  1: b = pattern_byte(0);
                  2: b = 8'h00;
                  default: b = 8'hFF;
               endcase
            end
            scan_byte(b, i == len - 1);
            i++;
            if ($urandom_range(99) < 3)
               load_entry($urandom_range(63), 8'($urandom_range(255)), 1'($urandom_range(1)));
         end
      end
   endtask

   task automatic run_random_regions(input int item_target);
      int start;
      start = sent_count;
      while (sent_count - start < item_target) begin
         if ($urandom_range(3) == 0) random_settings();
         random_region();
      end
   endtask

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------
   // Reset register values: length 1, first match, base 0.
   task automatic test_reset_defaults();
      load_entry(0, 8'hA5, 1'b0);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'hA5, 1'b0);   // found at offset 1
      scan_byte(8'hA5, 1'b0);   // dropped after the report
      scan_byte(8'hFF, 1'b1);   // closes the region silently
      scan_byte(8'h00, 1'b1);   // one-byte region, not found
      scan_byte(8'hA5, 1'b1);   // match on the last byte, no not-found after it
   endtask

   task automatic test_register_extremes();
      // Zero length and zero occurrence act as one; address wraps past the top.
      set_length(0);
      set_occurrence(0);
      write_csr(CSR_BASE_ADDRESS, 32'hFFFF_FFFF);
      scan_byte(8'h11, 1'b0);
      scan_byte(8'hA5, 1'b1);
      // Highest entry as don't-care, then a two-byte pattern, second match wanted.
      load_entry(63, 8'hFF, 1'b1);
      load_entry(1, 8'h00, 1'b0);
      set_length(2);
      set_occurrence(2);
      write_csr(CSR_BASE_ADDRESS, 32'h1000_0000);
      scan_byte(8'hA5, 1'b0);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'hA5, 1'b0);
      scan_byte(8'h00, 1'b1);
      // Don't-care tail; the highest occurrence never comes in a short region.
      load_entry(1, 8'h00, 1'b1);
      set_occurrence(65535);
      scan_byte(8'hA5, 1'b0);
      scan_byte(8'h3C, 1'b0);
      scan_byte(8'hA5, 1'b1);
   endtask

   // Full row: a length past the row clamps, then exactly the row.
   task automatic test_full_length();
      set_occurrence(1);
      set_length(127);
      fill_pattern();
      for (int k = 0; k < 3; k++) scan_byte(8'($urandom_range(255)), 1'b0);
      for (int p = 0; p < MAX_PATTERN; p++) scan_byte(pattern_byte(p), 1'b0);
      scan_byte(8'($urandom_range(255)), 1'b1);
      set_length(MAX_PATTERN);
      for (int p = 0; p < MAX_PATTERN; p++) scan_byte(pattern_byte(p), p == MAX_PATTERN - 1);
   endtask

   // Every byte matches; the report comes on a deep occurrence.
   task automatic test_occurrence_limit();
      set_length(1);
      load_entry(0, 8'($urandom_range(255)), 1'b1);
      set_occurrence(DEEP_OCCURRENCE);
      write_csr(CSR_BASE_ADDRESS, $urandom());
      for (int k = 0; k < DEEP_OCCURRENCE; k++) scan_byte(8'($urandom_range(255)), 1'b0);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'hFF, 1'b1);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_PATTERN_LENGTH;
      csr_data    = '0;
      reset       = 1'b1;
      set_idling(15, 77);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_extremes();
      test_full_length();
      run_random_regions(230);

      set_idling(77, 15);
      run_random_regions(230);

      set_idling(0, 0);
      run_random_regions(230);
      test_occurrence_limit();

      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_reports.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
